/* hdl/pspe_pkg.sv */
`timescale 1ns / 1ps

package pspe_pkg;

    localparam int MAX_DEG   = 20;
    localparam int NUM_COEFF = MAX_DEG + 1;
    localparam int COEFF_W   = 32;
    localparam int EXP_W     = 5;
    localparam int IDX_W     = $clog2(NUM_COEFF);
    localparam int CNT_W     = $clog2(NUM_COEFF + 1);
    localparam int DSUM_W    = IDX_W + 1;

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_CHECK = 5'b00010,
        S_ISSUE = 5'b00100,
        S_WAIT  = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    typedef struct packed {
        logic               en;
        logic [COEFF_W-1:0] a;
        logic [COEFF_W-1:0] b;
    } store_wr_t;

    typedef struct packed {
        logic             clear;
        logic [IDX_W-1:0] addr_a;
        logic [IDX_W-1:0] addr_b;
    } store_rd_t;

    typedef struct packed {
        logic [IDX_W-1:0] deg_a;
        logic [IDX_W-1:0] deg_b;
    } store_stat_t;

endpackage

/* hdl/pspe_if.sv */
`timescale 1ns / 1ps

interface pspe_load_if;
    import pspe_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COEFF_W-1:0] coeff_a;
    logic signed [COEFF_W-1:0] coeff_b;
    logic                      load_last;

    modport source (output valid, output coeff_a, output coeff_b, output load_last,
                    input ready);
    modport sink   (input valid, input coeff_a, input coeff_b, input load_last,
                    output ready);
endinterface

interface pspe_result_if;
    import pspe_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COEFF_W-1:0] coeff_out;
    logic        [EXP_W-1:0]   exponent;
    logic                      refused;
    logic                      run_last;

    modport source (output valid, output coeff_out, output exponent, output refused,
                    output run_last, input ready);
    modport sink   (input valid, input coeff_out, input exponent, input refused,
                    input run_last, output ready);
endinterface

/* hdl/poly_sum_product_engine_top.sv */
`timescale 1ns / 1ps

// Loads polynomials A and B one coefficient pair per word, one word a cycle, until the
// word marked load_last; then ready drops and a run emits MAX_DEG+1 result words,
// exponent 0 first, before loading opens again. Coefficients live in two memories
// with registered reads and are combined through a single shared 32x32 multiplier,
// or an adder in sum mode, and an accumulator. In product mode the word of exponent
// k reads pairs i = 0..k, each passing the read, multiply and accumulate registers
// before the word is output; sum mode and a refused product read one pair per word,
// and a refused product passes A through. A result waiting on ready stalls the run.
// Mode is sampled in the check state that follows the last word.

module poly_sum_product_engine_top
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    pspe_load_if.sink            load,
    pspe_result_if.source        result
);
    import pspe_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic               mode_reg;
    logic               prod_reg;
    logic               refused_reg;
    logic [IDX_W-1:0]   k_reg;
    logic [IDX_W-1:0]   i_reg;
    logic               v1_reg;
    logic               last1_reg;
    logic               first1_reg;
    logic               v2_reg;
    logic               last2_reg;
    logic               first2_reg;
    logic [COEFF_W-1:0] m_reg;
    logic [COEFF_W-1:0] acc_reg;

    store_wr_t          wr;
    store_rd_t          rd;
    store_stat_t        stat;
    logic [COEFF_W-1:0] rd_a;
    logic [COEFF_W-1:0] rd_b;
    logic [COEFF_W-1:0] mul_lo;
    logic               load_acc;
    logic               out_acc;
    logic               step_last;
    logic [DSUM_W-1:0]  deg_sum;

    pspe_store u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .rd    (rd),
        .rd_a  (rd_a),
        .rd_b  (rd_b),
        .stat  (stat)
    );

    assign load_acc  = load.valid && load.ready;
    assign out_acc   = result.valid && result.ready;
    assign step_last = !prod_reg || (i_reg == k_reg);
    assign deg_sum   = DSUM_W'(stat.deg_a) + DSUM_W'(stat.deg_b);
    assign mul_lo    = rd_a * rd_b;

    assign wr.en = load_acc;
    assign wr.a  = load.coeff_a;
    assign wr.b  = load.coeff_b;

    assign rd.clear  = out_acc && (k_reg == IDX_W'(MAX_DEG));
    assign rd.addr_a = prod_reg ? i_reg : k_reg;
    assign rd.addr_b = prod_reg ? (k_reg - i_reg) : k_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (load_acc && load.load_last)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_ISSUE;
            end
            S_ISSUE:
            begin
                if (step_last)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (v2_reg && last2_reg)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_acc)
                begin
                    state_next = (k_reg == IDX_W'(MAX_DEG)) ? S_LOAD : S_ISSUE;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            mode_reg    <= 1'b0;
            prod_reg    <= 1'b0;
            refused_reg <= 1'b0;
            k_reg       <= '0;
            i_reg       <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (state_reg == S_CHECK)
            begin
                refused_reg <= mode_reg && (deg_sum > DSUM_W'(MAX_DEG));
                prod_reg    <= mode_reg && !(deg_sum > DSUM_W'(MAX_DEG));
                k_reg       <= '0;
                i_reg       <= '0;
            end
            if (state_reg == S_ISSUE)
            begin
                i_reg <= step_last ? '0 : i_reg + IDX_W'(1);
            end
            if ((state_reg == S_OUT) && out_acc)
            begin
                k_reg <= k_reg + IDX_W'(1);
            end
            v1_reg <= (state_reg == S_ISSUE);
            v2_reg <= v1_reg;
        end
    end

    // read, multiply, add or pass A through, then accumulate
    always_ff @(posedge clk)
    begin
        last1_reg  <= step_last;
        first1_reg <= (i_reg == '0);
        last2_reg  <= last1_reg;
        first2_reg <= first1_reg;
        if (v1_reg)
        begin
            if (prod_reg)
            begin
                m_reg <= mul_lo;
            end
            else if (refused_reg)
            begin
                m_reg <= rd_a;
            end
            else
            begin
                m_reg <= rd_a + rd_b;
            end
        end
        if (v2_reg)
        begin
            acc_reg <= (first2_reg ? '0 : acc_reg) + m_reg;
        end
    end

    assign load.ready       = (state_reg == S_LOAD);
    assign result.valid     = (state_reg == S_OUT);
    assign result.coeff_out = acc_reg;
    assign result.exponent  = EXP_W'(k_reg);
    assign result.refused   = refused_reg;
    assign result.run_last  = (k_reg == IDX_W'(MAX_DEG));

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(load.ready && result.valid))
        else $error("load open during a run");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && result.run_last) |=> load.ready)
        else $error("run did not return to loading");

    a_exp_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && !result.run_last) |=> (k_reg == $past(k_reg) + IDX_W'(1)))
        else $error("exponent did not advance");

    a_pipe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (state_reg == S_ISSUE || state_reg == S_WAIT))
        else $error("accumulate outside a word");

endmodule

/* hdl/pspe_store.sv */
`timescale 1ns / 1ps

module pspe_store
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pspe_pkg::store_wr_t   wr,
    input  pspe_pkg::store_rd_t   rd,
    output logic [pspe_pkg::COEFF_W-1:0] rd_a,
    output logic [pspe_pkg::COEFF_W-1:0] rd_b,
    output pspe_pkg::store_stat_t stat
);
    import pspe_pkg::*;

    logic [COEFF_W-1:0] mem_a [NUM_COEFF];
    logic [COEFF_W-1:0] mem_b [NUM_COEFF];

    logic [CNT_W-1:0]   fill_reg;
    logic [IDX_W-1:0]   deg_a_reg;
    logic [IDX_W-1:0]   deg_b_reg;
    logic [COEFF_W-1:0] q_a_reg;
    logic [COEFF_W-1:0] q_b_reg;
    logic               hit_a_reg;
    logic               hit_b_reg;
    logic               room;
    logic [IDX_W-1:0]   waddr;

    assign room  = fill_reg < CNT_W'(NUM_COEFF);
    assign waddr = fill_reg[IDX_W-1:0];

    // entries at or above the fill count read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            deg_a_reg <= '0;
            deg_b_reg <= '0;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end
        else
        begin
            hit_a_reg <= CNT_W'(rd.addr_a) < fill_reg;
            hit_b_reg <= CNT_W'(rd.addr_b) < fill_reg;
            if (rd.clear)
            begin
                fill_reg  <= '0;
                deg_a_reg <= '0;
                deg_b_reg <= '0;
            end
            else if (wr.en && room)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
                if (wr.a != '0)
                begin
                    deg_a_reg <= waddr;
                end
                if (wr.b != '0)
                begin
                    deg_b_reg <= waddr;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && room && !rd.clear)
        begin
            mem_a[waddr] <= wr.a;
            mem_b[waddr] <= wr.b;
        end
        q_a_reg <= mem_a[rd.addr_a];
        q_b_reg <= mem_b[rd.addr_b];
    end

    assign rd_a       = hit_a_reg ? q_a_reg : '0;
    assign rd_b       = hit_b_reg ? q_b_reg : '0;
    assign stat.deg_a = deg_a_reg;
    assign stat.deg_b = deg_b_reg;

endmodule
